### hw/rtl/lse_pkg.sv
// Shared types and constants for the LSB stego extractor.
package lse_pkg;

    // Result kinds carried on the output tuser
    typedef enum logic [2:0] {
        KIND_EXT       = 3'd0,
        KIND_MSG       = 3'd1,
        KIND_MAGIC_BAD = 3'd2,
        KIND_EXT_LONG  = 3'd3,
        KIND_EMPTY     = 3'd4
    } kind_t;

    // Configuration register indexes
    localparam logic [0:0] CFG_MAGIC_LENGTH = 1'd0;
    localparam logic [0:0] CFG_MAGIC_CHARS  = 1'd1;

    // Configuration reset values: two magic characters, "#*"
    localparam logic [3:0]  MAGIC_LENGTH_RESET = 4'd2;
    localparam logic [63:0] MAGIC_CHARS_RESET  = 64'd10787;

    // Magic length bounds
    localparam logic [3:0] MAGIC_LEN_MIN = 4'd1;
    localparam logic [3:0] MAGIC_LEN_MAX = 4'd8;

    // Result of one cover byte
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] byte_value;
        logic       last;
    } result_t;

endpackage

### hw/rtl/lsb_stego_extractor_top.sv
// Top level of the LSB stego extractor: config registers, parser and result register.
//
//  Channel | Dir | Handshake         | Payload
//  --------+-----+-------------------+--------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | tdata: cover_byte; tuser: first_byte
//  m_*     | out | m_tvalid/m_tready | tdata: byte_value; tuser: kind; tlast: last
//  cfg_*   | in  | cfg_valid/ready   | cfg_index: register; cfg_data: value
//
// One cover byte per cycle while s_tready is high; each request is decoded in the cycle
// it is taken and its result, if any, lands in the output register on that edge.
// s_tready drops only while the output register holds a result that m_tready
// does not take, so a stalled sink holds back at most one result.
// rst_n clears parse state to header skip and loads the default magic "#*".
module lsb_stego_extractor_top #(
    parameter int HEADER_BYTES = 54,
    parameter int MAX_EXT_LEN  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] cover_byte
    input  logic [0:0]  s_tuser,    // [0] first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] byte_value
    output logic [2:0]  m_tuser,    // [2:0] kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import lse_pkg::*;

    logic [3:0]  magic_length_reg;
    logic [63:0] magic_chars_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     result;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            magic_length_reg <= MAGIC_LENGTH_RESET;
            magic_chars_reg  <= MAGIC_CHARS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MAGIC_LENGTH: magic_length_reg <= cfg_data[3:0];
                CFG_MAGIC_CHARS:  magic_chars_reg  <= cfg_data;
                default:          magic_length_reg <= magic_length_reg;
            endcase
        end
    end

    lse_parser #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_EXT_LEN  (MAX_EXT_LEN)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cover_bit    (s_tdata[0]),
        .first_byte   (s_tuser[0]),
        .magic_length (magic_length_reg),
        .magic_chars  (magic_chars_reg),
        .result       (result)
    );

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= accept && result.valid;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept && result.valid)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.byte_value;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

### hw/rtl/lse_parser.sv
// Parse state machine: header skip, bit gathering and phase decoding.
module lse_parser #(
    parameter int HEADER_BYTES = 54,
    parameter int MAX_EXT_LEN  = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,       // a cover byte request is taken
    input  logic            cover_bit,    // bit 0 of the cover byte
    input  logic            first_byte,
    input  logic [3:0]      magic_length,
    input  logic [63:0]     magic_chars,
    output lse_pkg::result_t result
);
    import lse_pkg::*;

    localparam int HDR_W = (HEADER_BYTES < 1) ? 1 : $clog2(HEADER_BYTES + 1);

    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_MAGIC   = 7'b0000010,
        PH_EXT_LEN = 7'b0000100,
        PH_EXT     = 7'b0001000,
        PH_MSG_LEN = 7'b0010000,
        PH_MSG     = 7'b0100000,
        PH_HALT    = 7'b1000000
    } phase_t;

    phase_t             phase_reg,  phase_next;
    logic [HDR_W-1:0]   hcnt_reg,   hcnt_next;
    logic [4:0]         bidx_reg,   bidx_next;
    logic [31:0]        acc_reg,    acc_next;
    logic [31:0]        rem_reg,    rem_next;
    logic [3:0]         midx_reg,   midx_next;

    // State as seen by this byte, after a restart on first_byte
    phase_t             eff_phase;
    phase_t             work_phase;
    logic [HDR_W-1:0]   eff_hcnt;
    logic [4:0]         eff_bidx;
    logic [31:0]        eff_rem;
    logic [3:0]         eff_midx;
    logic [3:0]         mag_len;
    logic [3:0]         midx_inc;
    logic [7:0]         new_byte;
    logic [31:0]        new_word;
    logic [31:0]        rem_dec;
    logic [7:0]         expect_char;

    always_comb
    begin
        eff_phase = first_byte ? PH_HEADER : phase_reg;
        eff_hcnt  = first_byte ? '0 : hcnt_reg;
        eff_bidx  = first_byte ? '0 : bidx_reg;
        eff_rem   = first_byte ? '0 : rem_reg;
        eff_midx  = first_byte ? '0 : midx_reg;
    end

    // Gathered values, lowest bit first: new bit enters at the top
    assign acc_next    = {cover_bit, acc_reg[31:1]};
    assign new_byte    = {cover_bit, acc_reg[31:25]};
    assign new_word    = {cover_bit, acc_reg[31:1]};
    assign rem_dec     = eff_rem - 32'd1;
    assign midx_inc    = eff_midx + 4'd1;
    assign expect_char = magic_chars[{eff_midx[2:0], 3'b000} +: 8];

    // Clamp the configured magic length to 1..8
    always_comb
    begin
        if (magic_length < MAGIC_LEN_MIN)
            mag_len = MAGIC_LEN_MIN;
        else if (magic_length > MAGIC_LEN_MAX)
            mag_len = MAGIC_LEN_MAX;
        else
            mag_len = magic_length;
    end

    // Next state and result for one cover byte
    always_comb
    begin
        work_phase = eff_phase;
        hcnt_next  = eff_hcnt;
        bidx_next  = eff_bidx + 5'd1;
        rem_next   = eff_rem;
        midx_next  = eff_midx;
        result     = '0;
        result.kind = KIND_EXT;

        // Header bytes are counted; the byte after them is already data
        if (eff_phase == PH_HEADER) begin
            if (eff_hcnt < HDR_W'(HEADER_BYTES))
                hcnt_next = eff_hcnt + HDR_W'(1);
            else
                work_phase = PH_MAGIC;
        end
        phase_next = work_phase;

        case (work_phase)
            PH_HEADER:
            begin
                bidx_next = eff_bidx;
            end
            PH_MAGIC:
            begin
                if (eff_bidx == 5'd7) begin
                    bidx_next = '0;
                    if (new_byte != expect_char) begin
                        phase_next        = PH_HALT;
                        result.valid      = 1'b1;
                        result.kind       = KIND_MAGIC_BAD;
                        result.last       = 1'b1;
                    end else begin
                        midx_next = midx_inc;
                        if (midx_inc >= mag_len)
                            phase_next = PH_EXT_LEN;
                    end
                end
            end
            PH_EXT_LEN:
            begin
                if (eff_bidx == 5'd31) begin
                    bidx_next = '0;
                    rem_next  = new_word;
                    if (new_word > 32'(MAX_EXT_LEN)) begin
                        phase_next   = PH_HALT;
                        result.valid = 1'b1;
                        result.kind  = KIND_EXT_LONG;
                        result.last  = 1'b1;
                    end else if (new_word == '0) begin
                        phase_next = PH_MSG_LEN;
                    end else begin
                        phase_next = PH_EXT;
                    end
                end
            end
            PH_EXT:
            begin
                if (eff_bidx == 5'd7) begin
                    bidx_next         = '0;
                    rem_next          = rem_dec;
                    if (rem_dec == '0)
                        phase_next = PH_MSG_LEN;
                    result.valid      = 1'b1;
                    result.kind       = KIND_EXT;
                    result.byte_value = new_byte;
                end
            end
            PH_MSG_LEN:
            begin
                if (eff_bidx == 5'd31) begin
                    bidx_next = '0;
                    rem_next  = new_word;
                    if (new_word == '0) begin
                        phase_next   = PH_HALT;
                        result.valid = 1'b1;
                        result.kind  = KIND_EMPTY;
                        result.last  = 1'b1;
                    end else begin
                        phase_next = PH_MSG;
                    end
                end
            end
            PH_MSG:
            begin
                if (eff_bidx == 5'd7) begin
                    bidx_next         = '0;
                    rem_next          = rem_dec;
                    result.valid      = 1'b1;
                    result.kind       = KIND_MSG;
                    result.byte_value = new_byte;
                    if (rem_dec == '0) begin
                        phase_next  = PH_HALT;
                        result.last = 1'b1;
                    end
                end
            end
            default:
            begin
                // Halted: ignore bytes until the next first byte
                bidx_next = eff_bidx;
            end
        endcase
    end

    // Parse control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_HEADER;
            hcnt_reg  <= '0;
            bidx_reg  <= '0;
            rem_reg   <= '0;
            midx_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            bidx_reg  <= bidx_next;
            rem_reg   <= rem_next;
            midx_reg  <= midx_next;
        end
    end

    // Bit shift register; every gathered value is fully refilled before use
    always_ff @(posedge clk)
    begin
        if (accept)
            acc_reg <= acc_next;
    end

endmodule

### sim/lsb_stego_extractor_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for lsb_stego_extractor_top: cover images and decoded results.
module lsb_stego_extractor_top_tb;
    import lse_pkg::*;

    localparam int HEADER_BYTES   = 54;
    localparam int MAX_EXT_LEN    = 16;
    localparam int RANDOM_IMAGES  = 2;
    localparam int TRAIL_BYTES    = 3;
    localparam int DRAIN_CYCLES   = 4;
    localparam int STALL_LIMIT    = 1000;
    localparam int MAX_REPORTS    = 10;

    // Parser phases of the decoder
    typedef enum logic [6:0] {
        ST_HEADER  = 7'b0000001,
        ST_MAGIC   = 7'b0000010,
        ST_EXT_LEN = 7'b0000100,
        ST_EXT     = 7'b0001000,
        ST_MSG_LEN = 7'b0010000,
        ST_MSG     = 7'b0100000,
        ST_HALT    = 7'b1000000
    } parse_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } decoded_item_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;    // [7:0] cover_byte
    logic [0:0]  s_tuser   = 1'b0;     // [0] first_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;              // [7:0] byte_value
    logic [2:0]  m_tuser;              // [2:0] kind
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = CFG_MAGIC_LENGTH;
    logic [63:0] cfg_data  = 64'h0;

    // Decoder shadow: configuration and parse state
    logic [3:0]   magic_len_cfg;
    logic [63:0]  magic_chars_cfg;
    parse_state_t parse_state;
    int           hdr_count;
    int           bit_pos;
    logic [31:0]  bit_acc;
    logic [31:0]  remaining;
    int           magic_pos;

    decoded_item_t pending_results[$];

    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;
    int errors      = 0;
    int bytes_sent  = 0;
    int images_sent = 0;
    int settings    = 0;
    int kind_seen[5];
    int stall_cycles = 0;

    lsb_stego_extractor_top #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_EXT_LEN  (MAX_EXT_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder shadow
    // ------------------------------------------------------------------
    function automatic void clear_parse();
        parse_state = ST_HEADER;
        hdr_count   = 0;
        bit_pos     = 0;
        bit_acc     = 32'h0;
        remaining   = 32'h0;
        magic_pos   = 0;
    endfunction

    // Magic length with out-of-range settings clamped to 1..8
    function automatic int eff_magic_len();
        if (magic_len_cfg < MAGIC_LEN_MIN)
            return int'(MAGIC_LEN_MIN);
        if (magic_len_cfg > MAGIC_LEN_MAX)
            return int'(MAGIC_LEN_MAX);
        return int'(magic_len_cfg);
    endfunction

    // Shift one LSB into the accumulator; 1 once need bits are in
    function automatic bit gather_bit(input logic b, input int need);
        bit_acc = bit_acc | (32'(b) << bit_pos);
        bit_pos++;
        if (bit_pos >= need)
        begin
            bit_pos = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void push_decoded(input kind_t k, input logic [7:0] v, input logic l);
        decoded_item_t item;
        item.kind  = k;
        item.value = v;
        item.last  = l;
        pending_results.push_back(item);
    endfunction

    // Advance the shadow by one cover byte, queueing any result it causes
    function automatic void decode_cover_byte(input logic [7:0] b, input logic first);
        logic [7:0] ch;
        if (first)
            clear_parse();
        if (parse_state == ST_HEADER)
        begin
            if (hdr_count < HEADER_BYTES)
            begin
                hdr_count++;
                return;
            end
            parse_state = ST_MAGIC;
        end
        case (parse_state)
            ST_MAGIC:
            begin
                if (!gather_bit(b[0], 8))
                    return;
                ch      = bit_acc[7:0];
                bit_acc = 32'h0;
                if (ch != magic_chars_cfg[(magic_pos % 8) * 8 +: 8])
                begin
                    parse_state = ST_HALT;
                    push_decoded(KIND_MAGIC_BAD, 8'h00, 1'b1);
                    return;
                end
                magic_pos++;
                if (magic_pos >= eff_magic_len())
                    parse_state = ST_EXT_LEN;
            end
            ST_EXT_LEN:
            begin
                if (!gather_bit(b[0], 32))
                    return;
                remaining = bit_acc;
                bit_acc   = 32'h0;
                if (remaining > 32'(MAX_EXT_LEN))
                begin
                    parse_state = ST_HALT;
                    push_decoded(KIND_EXT_LONG, 8'h00, 1'b1);
                    return;
                end
                parse_state = (remaining == 32'h0) ? ST_MSG_LEN : ST_EXT;
            end
            ST_EXT:
            begin
                if (!gather_bit(b[0], 8))
                    return;
                ch        = bit_acc[7:0];
                bit_acc   = 32'h0;
                remaining = remaining - 32'd1;
                if (remaining == 32'h0)
                    parse_state = ST_MSG_LEN;
                push_decoded(KIND_EXT, ch, 1'b0);
            end
            ST_MSG_LEN:
            begin
                if (!gather_bit(b[0], 32))
                    return;
                remaining = bit_acc;
                bit_acc   = 32'h0;
                if (remaining == 32'h0)
                begin
                    parse_state = ST_HALT;
                    push_decoded(KIND_EMPTY, 8'h00, 1'b1);
                    return;
                end
                parse_state = ST_MSG;
            end
            ST_MSG:
            begin
                bit done;
                done = gather_bit(b[0], 8);
                if (!done)
                    return;
                ch        = bit_acc[7:0];
                bit_acc   = 32'h0;
                remaining = remaining - 32'd1;
                if (remaining == 32'h0)
                begin
                    parse_state = ST_HALT;
                    push_decoded(KIND_MSG, ch, 1'b1);
                end
                else
                    push_decoded(KIND_MSG, ch, 1'b0);
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Image building
    // ------------------------------------------------------------------
    // Append n bits of v as cover bytes, LSB carrying the bit, lowest bit first
    function automatic void push_bits(ref logic [7:0] img[$], input logic [31:0] v,
                                      input int n);
        logic [7:0] cb;
        for (int i = 0; i < n; i++)
        begin
            cb    = 8'($urandom);
            cb[0] = v[i];
            img.push_back(cb);
        end
    endfunction

    function automatic void build_image(ref logic [7:0] img[$], input logic [63:0] magic,
                                        input int n_magic, input logic [31:0] ext_len,
                                        input int n_ext, input logic [31:0] msg_len,
                                        input int n_msg);
        img.delete();
        for (int i = 0; i < HEADER_BYTES; i++)
            img.push_back(8'($urandom));
        for (int k = 0; k < n_magic; k++)
            push_bits(img, 32'(magic[k * 8 +: 8]), 8);
        push_bits(img, ext_len, 32);
        for (int k = 0; k < n_ext; k++)
            push_bits(img, $urandom, 8);
        push_bits(img, msg_len, 32);
        for (int k = 0; k < n_msg; k++)
            push_bits(img, $urandom, 8);
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_cover(input logic [7:0] b, input logic first);
        int gap;
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        decode_cover_byte(b, first);
    endtask

    // Send the first cut bytes of an image; only its first byte is flagged
    task automatic send_image(ref logic [7:0] img[$], input int cut);
        for (int i = 0; i < cut && i < img.size(); i++)
            send_cover(img[i], i == 0);
        images_sent++;
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            send_cover(8'($urandom), 1'b0);
    endtask

    // Well-formed image under the current magic setting
    task automatic send_good_image(input int n_ext, input int n_msg);
        logic [7:0] img[$];
        build_image(img, magic_chars_cfg, eff_magic_len(), 32'(n_ext), n_ext,
                    32'(n_msg), n_msg);
        send_image(img, img.size());
    endtask

    // Image whose magic differs from the setting in character pos; a few
    // bytes after the halt are sent and must be ignored
    task automatic send_bad_magic_image(input int pos);
        logic [7:0]  img[$];
        logic [63:0] flip;
        flip = 64'($urandom_range(1, 255)) << (8 * pos);
        build_image(img, magic_chars_cfg ^ flip, eff_magic_len(), 32'd1, 1, 32'd2, 2);
        send_image(img, HEADER_BYTES + 8 * (pos + 1) + TRAIL_BYTES);
    endtask

    // Image whose extension length is over the bound, cut shortly after it
    task automatic send_long_ext_image(input logic [31:0] ext_len);
        logic [7:0] img[$];
        build_image(img, magic_chars_cfg, eff_magic_len(), ext_len, 0, 32'd1, 1);
        send_image(img, HEADER_BYTES + 8 * eff_magic_len() + 32 + TRAIL_BYTES);
    endtask

    task automatic send_image_lengths(input logic [31:0] ext_len, input int n_ext,
                                      input logic [31:0] msg_len, input int n_msg);
        logic [7:0] img[$];
        build_image(img, magic_chars_cfg, eff_magic_len(), ext_len, n_ext, msg_len, n_msg);
        send_image(img, img.size());
    endtask

    // Hold off the sender until every expected result has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both magic registers; only called with the block idle
    task automatic set_magic(input logic [3:0] len, input logic [63:0] chars);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MAGIC_LENGTH;
        cfg_data  <= 64'(len);
        do
            @(posedge clk);
        while (!cfg_ready);
        magic_len_cfg = len;
        cfg_index <= CFG_MAGIC_CHARS;
        cfg_data  <= chars;
        do
            @(posedge clk);
        while (!cfg_ready);
        magic_chars_cfg = chars;
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // ------------------------------------------------------------------
    // Result sink with random stalls
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (snk_idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        decoded_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: kind %0d byte %02h last %0d",
                             m_tuser, m_tdata, m_tlast);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser < 3'd5)
                    kind_seen[m_tuser]++;
                if (m_tuser != want.kind || m_tdata != want.value || m_tlast != want.last)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: exp %0d/%02h/%0d got %0d/%02h/%0d (kind/byte/last)",
                                 want.kind, want.value, want.last, m_tuser, m_tdata, m_tlast);
                end
            end
        end
    end

    // Watchdog: too long without any request moving on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL lsb_stego_extractor_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings ("#*", two characters) decode a normal image
    task automatic test_default_magic();
        send_good_image(1, 2);
    endtask

    // Last magic character wrong, then bytes after the halt
    task automatic test_magic_mismatch();
        send_bad_magic_image(eff_magic_len() - 1);
    endtask

    // Extension at the bound, then a length just over it
    task automatic test_extension_bounds();
        send_image_lengths(32'(MAX_EXT_LEN), MAX_EXT_LEN, 32'd0, 0);
        send_long_ext_image(32'(MAX_EXT_LEN + 1));
    endtask

    // Zero extension followed by an empty message
    task automatic test_empty_message();
        send_image_lengths(32'd0, 0, 32'd0, 0);
    endtask

    // New first byte in the header, in the magic and mid message;
    // the next image restarts the last one
    task automatic test_restart();
        logic [7:0] img[$];
        build_image(img, magic_chars_cfg, eff_magic_len(), 32'd0, 0, 32'd1, 1);
        send_image(img, 20);
        send_image(img, HEADER_BYTES + 5);
        send_image(img, img.size() - 3);
    endtask

    // Clamped lengths: 0 acts as 1 with an all-zero magic, 15 acts as 8
    task automatic test_magic_settings();
        set_magic(4'd0, 64'h0);
        send_image_lengths(32'd0, 0, 32'd0, 0);
        set_magic(4'd15, {$urandom, $urandom});
        send_good_image(0, 1);
    endtask

    // Mostly well-formed images with random content, plus broken ones
    task automatic test_random_images();
        logic [7:0]  img[$];
        logic [31:0] len;
        int          n_ext;
        int          cut;
        for (int n = 0; n < RANDOM_IMAGES; n++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       set_magic(4'($urandom_range(0, 15)), {$urandom, $urandom});
                    default: set_magic(4'($urandom_range(1, 8)), {$urandom, $urandom});
                endcase
            end
            if (n == 0 || $urandom_range(0, 5) == 0)
                wait_drained();
            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                6:
                    send_bad_magic_image($urandom_range(0, eff_magic_len() - 1));
                7:
                begin
                    len = $urandom;
                    if (len <= 32'(MAX_EXT_LEN))
                        len = 32'(MAX_EXT_LEN + 1) + len;
                    send_long_ext_image(len);
                end
                8:
                    send_image_lengths(32'($urandom_range(0, 3)), 0, 32'd0, 0);
                9:
                begin
                    // long message length, cut off by the next image
                    n_ext = $urandom_range(0, 2);
                    build_image(img, magic_chars_cfg, eff_magic_len(), 32'(n_ext), n_ext,
                                $urandom | 32'h0000_0100, 3);
                    cut = $urandom_range(1, img.size());
                    send_image(img, cut);
                end
                default:
                begin
                    n_ext = ($urandom_range(0, 9) == 0) ? MAX_EXT_LEN : $urandom_range(0, 4);
                    send_good_image(n_ext, $urandom_range(1, 10));
                    if ($urandom_range(0, 2) == 0)
                        send_noise($urandom_range(1, 6));
                end
            endcase
        end
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_full_rate();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        send_good_image(1, 1);
    endtask

    initial
    begin
        magic_len_cfg   = MAGIC_LENGTH_RESET;
        magic_chars_cfg = MAGIC_CHARS_RESET;
        clear_parse();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_default_magic();
        test_magic_mismatch();
        test_extension_bounds();
        test_empty_message();
        test_restart();
        test_magic_settings();
        test_random_images();
        test_full_rate();

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Sent %0d cover bytes in %0d images over %0d magic settings",
                 bytes_sent, images_sent, settings + 1);
        $display("Results seen: %0d ext, %0d msg, %0d bad magic, %0d ext too long, %0d empty",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (errors == 0 && pending_results.size() == 0)
            $display("PASS lsb_stego_extractor_top");
        else
            $display("FAIL lsb_stego_extractor_top");
        $finish;
    end

endmodule

### files.f
hw/rtl/lse_pkg.sv
hw/rtl/lse_parser.sv
hw/rtl/lsb_stego_extractor_top.sv
sim/lsb_stego_extractor_top_tb.sv
